@@ rtl/servo_instruction_packet_builder_core_macros.svh @@
// Assertion macros for the servo instruction packet builder checker.
// Used by sipb_checker; no other dependencies.
`ifndef SERVO_INSTRUCTION_PACKET_BUILDER_CORE_MACROS_SVH
`define SERVO_INSTRUCTION_PACKET_BUILDER_CORE_MACROS_SVH

// Implication to the next cycle, switched off while in reset.
`define SIPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication to the next cycle, also checked across reset.
`define SIPB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sipb_pkg.sv @@
// Shared types and constants of the servo instruction packet builder.
// No dependencies.
`default_nettype none

package sipb_pkg;

   typedef enum logic [1:0] {
      CMD_PING  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_RESET = 2'd3
   } command_type;

   localparam logic [7:0] HDR_BYTE  = 8'hFF;
   localparam logic [7:0] INS_PING  = 8'h01;
   localparam logic [7:0] INS_READ  = 8'h02;
   localparam logic [7:0] INS_WRITE = 8'h03;
   localparam logic [7:0] INS_RESET = 8'h06;

   localparam logic [7:0] LEN_NO_PARAM  = 8'h02;
   localparam logic [7:0] LEN_ONE_PARAM = 8'h04;
   localparam logic [7:0] LEN_TWO_PARAM = 8'h05;

   // byte positions within a packet
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] POS_HDR0 = 4'd0;
   localparam logic [POS_W-1:0] POS_HDR1 = 4'd1;
   localparam logic [POS_W-1:0] POS_ID   = 4'd2;
   localparam logic [POS_W-1:0] POS_LEN  = 4'd3;
   localparam logic [POS_W-1:0] POS_INS  = 4'd4;
   localparam logic [POS_W-1:0] POS_ADDR = 4'd5;
   localparam logic [POS_W-1:0] POS_P0   = 4'd6;
   localparam logic [POS_W-1:0] POS_P1   = 4'd7;
   localparam logic [POS_W-1:0] LAST_NO_PARAM  = 4'd5;
   localparam logic [POS_W-1:0] LAST_ONE_PARAM = 4'd7;
   localparam logic [POS_W-1:0] LAST_TWO_PARAM = 4'd8;

   // one classified packet, ready for serialising
   typedef struct packed {
      logic [7:0]       servo_id;
      logic [7:0]       len;
      logic [7:0]       ins;
      logic [7:0]       addr;
      logic [7:0]       param0;
      logic [7:0]       param1;
      logic [7:0]       checksum;
      logic [POS_W-1:0] last_pos;
   } packet_type;

endpackage

`default_nettype wire

@@ rtl/sipb_front.sv @@
// Front end: takes a request word and classifies it into a packet descriptor.
// Depends on sipb_pkg.
`default_nettype none

module sipb_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_servo_id,
   input  wire logic [7:0]        req_reg_address,
   input  wire logic [15:0]       req_value,
   input  wire logic [7:0]        req_byte_count,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output sipb_pkg::packet_type   push_packet
);
   import sipb_pkg::*;

   packet_type pkt;
   logic [7:0] addr_term;
   logic [7:0] p0_term;
   logic [7:0] p1_term;

   always_comb begin
      pkt          = '0;
      pkt.servo_id = req_servo_id;
      pkt.addr     = req_reg_address;
      pkt.param0   = req_value[7:0];
      pkt.param1   = req_value[15:8];
      addr_term    = 8'h00;
      p0_term      = 8'h00;
      p1_term      = 8'h00;
      case (command_type'(req_command))
         CMD_PING: begin
            pkt.ins      = INS_PING;
            pkt.len      = LEN_NO_PARAM;
            pkt.last_pos = LAST_NO_PARAM;
         end
         CMD_READ: begin
            pkt.ins      = INS_READ;
            pkt.len      = LEN_ONE_PARAM;
            pkt.param0   = req_byte_count;
            pkt.last_pos = LAST_ONE_PARAM;
            addr_term    = req_reg_address;
            p0_term      = req_byte_count;
         end
         CMD_WRITE: begin
            pkt.ins   = INS_WRITE;
            addr_term = req_reg_address;
            p0_term   = req_value[7:0];
            // any count but two falls back to a single-byte write
            if (req_byte_count == 8'd2) begin
               pkt.len      = LEN_TWO_PARAM;
               pkt.last_pos = LAST_TWO_PARAM;
               p1_term      = req_value[15:8];
            end else begin
               pkt.len      = LEN_ONE_PARAM;
               pkt.last_pos = LAST_ONE_PARAM;
            end
         end
         default: begin
            pkt.ins      = INS_RESET;
            pkt.len      = LEN_NO_PARAM;
            pkt.last_pos = LAST_NO_PARAM;
         end
      endcase
      pkt.checksum = HDR_BYTE - (req_servo_id + pkt.len + pkt.ins + addr_term
                                 + p0_term + p1_term);
   end

   assign push_packet = pkt;
   assign push_valid  = req_valid;
   assign req_ready   = push_ready;

endmodule

`default_nettype wire

@@ rtl/sipb_queue.sv @@
// Small descriptor queue between the front end and the serialiser.
// Depends on sipb_pkg.
`default_nettype none

module sipb_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire sipb_pkg::packet_type push_packet,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output sipb_pkg::packet_type      pop_packet
);
   import sipb_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   packet_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_packet = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_packet;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sipb_back.sv @@
// Back end: serialises one packet descriptor into bytes through an output register.
// Depends on sipb_pkg.
`default_nettype none

module sipb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire sipb_pkg::packet_type pop_packet,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_last_byte
);
   import sipb_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             load;
   logic             at_end;
   logic [7:0]       body_byte;

   assign load   = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign at_end = (pos_ff == pop_packet.last_pos);
   assign pop_ready = load && at_end;

   always_comb begin
      case (pos_ff)
         POS_HDR0: body_byte = HDR_BYTE;
         POS_HDR1: body_byte = HDR_BYTE;
         POS_ID:   body_byte = pop_packet.servo_id;
         POS_LEN:  body_byte = pop_packet.len;
         POS_INS:  body_byte = pop_packet.ins;
         POS_ADDR: body_byte = pop_packet.addr;
         POS_P0:   body_byte = pop_packet.param0;
         POS_P1:   body_byte = pop_packet.param1;
         default:  body_byte = HDR_BYTE;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = at_end ? pop_packet.checksum : body_byte;
         rsp_last_in  = at_end;
         pos_in       = at_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/servo_instruction_packet_builder_core.sv @@
// Top level of the servo instruction packet builder: front end, queue, serialiser.
// Depends on sipb_pkg, sipb_front, sipb_queue and sipb_back.
//
//   channel | direction | word
//   --------+-----------+--------------------------------------------------
//   req     | in        | command, servo id, address, value, byte count
//   rsp     | out       | one packet byte, flagged on the closing checksum
//
// Each request becomes a packet of 6 (ping, reset), 8 (read, one-byte write) or 9
// (two-byte write) bytes, sent one byte per cycle while rsp is not stalled.
// The packet being sent keeps its queue slot until its checksum is loaded, so
// up to QUEUE_DEPTH - 1 further requests wait behind it. A stall on rsp holds
// the output register and backs up into the queue.
// Reset empties the queue and the output register.
`default_nettype none

module servo_instruction_packet_builder_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_servo_id,
   input  wire logic [7:0]  req_reg_address,
   input  wire logic [15:0] req_value,
   input  wire logic [7:0]  req_byte_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_byte
);
   import sipb_pkg::*;

   logic       push_valid, push_ready;
   packet_type push_packet;
   logic       pop_valid, pop_ready;
   packet_type pop_packet;

   sipb_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_servo_id    (req_servo_id),
      .req_reg_address (req_reg_address),
      .req_value       (req_value),
      .req_byte_count  (req_byte_count),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_packet     (push_packet)
   );

   sipb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_packet (push_packet),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_packet  (pop_packet)
   );

   sipb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_packet    (pop_packet),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

@@ rtl/sipb_checker.sv @@
// Port-level checks for the servo instruction packet builder, bound to the top.
// Depends on sipb_pkg and servo_instruction_packet_builder_core_macros.svh.
`default_nettype none

`include "servo_instruction_packet_builder_core_macros.svh"

module sipb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_last_byte
);
   import sipb_pkg::*;

   logic       rsp_stall;
   logic       rsp_end;
   logic [8:0] rsp_word;
   logic       rsp_opens;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_end   = rsp_valid && rsp_ready && rsp_last_byte;
   assign rsp_word  = {rsp_tx_byte, rsp_last_byte};
   assign rsp_opens = !rsp_valid || (rsp_tx_byte == HDR_BYTE && !rsp_last_byte);

   `SIPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "rsp word dropped")
   `SIPB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_word), "rsp word changed")
   // a packet always opens with the header byte
   `SIPB_ASSERT_NEXT(a_hdr_after_end, clock, reset, rsp_end, rsp_opens, "no header")
   // reset leaves the queue able to take a request and nothing on rsp
   `SIPB_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid && req_ready, "not clear")

endmodule

bind servo_instruction_packet_builder_core sipb_checker u_sipb_checker (.*);

`default_nettype wire

@@ tb/sv/servo_instruction_packet_builder_core_test.sv @@
// Testbench for servo_instruction_packet_builder_core: directed and random requests,
// every packet byte checked against a local packet builder.
// Depends on sipb_pkg and the RTL of the core.

module servo_instruction_packet_builder_core_test;
   import sipb_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } packet_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_PING;
   logic [7:0]  req_servo_id = 8'h00;
   logic [7:0]  req_reg_address = 8'h00;
   logic [15:0] req_value = 16'h0000;
   logic [7:0]  req_byte_count = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;

   packet_byte_type pending_packet_bytes[$];
   int              error_count = 0;
   bit              no_idle = 1'b0;

   servo_instruction_packet_builder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_servo_id    (req_servo_id),
      .req_reg_address (req_reg_address),
      .req_value       (req_value),
      .req_byte_count  (req_byte_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   always #1 clock = ~clock;

   function automatic int draw_wait();
      if (no_idle) return 0;
      return int'($urandom_range(0, 14));
   endfunction

   // Appends the whole instruction packet for one request to the expected bytes.
   function automatic void queue_packet(input command_type cmd, input logic [7:0] id,
                                        input logic [7:0] addr, input logic [15:0] val,
                                        input logic [7:0] count);
      logic [7:0] ins;
      logic [7:0] params[$];
      logic [7:0] body[$];
      logic [7:0] sum;
      sum = 8'h00;
      case (cmd)
         CMD_PING: ins = INS_PING;
         CMD_READ: begin
            ins = INS_READ;
            params.push_back(addr);
            params.push_back(count);
         end
         CMD_WRITE: begin
            ins = INS_WRITE;
            params.push_back(addr);
            params.push_back(val[7:0]);
            // any count but two falls back to a one-byte write
            if (count == 8'd2) params.push_back(val[15:8]);
         end
         default: ins = INS_RESET;
      endcase
      body.push_back(id);
      body.push_back(8'(params.size() + 2));
      body.push_back(ins);
      foreach (params[i]) body.push_back(params[i]);
      pending_packet_bytes.push_back('{HDR_BYTE, 1'b0});
      pending_packet_bytes.push_back('{HDR_BYTE, 1'b0});
      foreach (body[i]) begin
         pending_packet_bytes.push_back('{body[i], 1'b0});
         sum = sum + body[i];
      end
      pending_packet_bytes.push_back('{8'hFF - sum, 1'b1});
   endfunction

   // Prediction on the request side, checking on the result side, in one process
   always @(posedge clock) begin
      packet_byte_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            queue_packet(command_type'(req_command), req_servo_id, req_reg_address,
                         req_value, req_byte_count);
         if (rsp_valid && rsp_ready) begin
            if (pending_packet_bytes.size() == 0) begin
               $display("%0t: unexpected word: tx_byte %02h last_byte %0b",
                        $time, rsp_tx_byte, rsp_last_byte);
               error_count++;
            end else begin
               want = pending_packet_bytes.pop_front();
               if (rsp_tx_byte !== want.tx_byte) begin
                  $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                           $time, want.tx_byte, rsp_tx_byte);
                  error_count++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                           $time, want.last_byte, rsp_last_byte);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random stall before each word
   initial begin
      int stall;
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Leaves valid high on return so the next word can follow without a gap.
   task automatic send_request(input command_type cmd, input logic [7:0] id,
                               input logic [7:0] addr, input logic [15:0] val,
                               input logic [7:0] count);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_servo_id    <= id;
      req_reg_address <= addr;
      req_value       <= val;
      req_byte_count  <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_request();
      command_type cmd;
      logic [7:0]  count;
      cmd = command_type'(2'($urandom_range(0, 3)));
      count = 8'($urandom_range(0, 255));
      // two-byte writes are otherwise rare
      if (cmd == CMD_WRITE && $urandom_range(0, 1) != 0) count = 8'd2;
      send_request(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), count);
   endtask

   task automatic test_ping_and_reset();
      send_request(CMD_PING, 8'h00, 8'h00, 16'h0000, 8'h00);
      send_request(CMD_PING, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_request(CMD_PING, 8'hFC, 8'h5A, 16'h1234, 8'h02);    // checksum 00
      send_request(CMD_RESET, 8'h00, 8'h00, 16'h0000, 8'h00);
      send_request(CMD_RESET, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_read();
      send_request(CMD_READ, 8'h01, 8'h00, 16'hFFFF, 8'h00);
      send_request(CMD_READ, 8'hFF, 8'hFF, 16'h0000, 8'hFF);
      send_request(CMD_READ, 8'h5A, 8'h24, 16'h1234, 8'h02);
      send_request(CMD_READ, 8'hF9, 8'h00, 16'h8000, 8'h00);    // checksum 00
   endtask

   task automatic test_write_one_byte();
      send_request(CMD_WRITE, 8'h01, 8'h1E, 16'hFFFF, 8'h00);   // high byte dropped
      send_request(CMD_WRITE, 8'hFF, 8'hFF, 16'hABCD, 8'h01);
      send_request(CMD_WRITE, 8'h03, 8'h20, 16'h00FF, 8'h03);
      send_request(CMD_WRITE, 8'h00, 8'h00, 16'h0000, 8'hFF);
   endtask

   task automatic test_write_two_bytes();
      send_request(CMD_WRITE, 8'h01, 8'h1E, 16'h0200, 8'h02);
      send_request(CMD_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 8'h02);   // sum wraps four times
      send_request(CMD_WRITE, 8'h00, 8'h00, 16'h0000, 8'h02);
      send_request(CMD_WRITE, 8'h7E, 8'h81, 16'h8001, 8'h02);
   endtask

   task automatic test_random_mix(input int n);
      repeat (n) send_random_request();
   endtask

   // No idling on either side: queue fills and backs up
   task automatic test_back_to_back(input int n);
      no_idle = 1'b1;
      repeat (n) send_random_request();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_ping_and_reset();
      test_read();
      test_write_one_byte();
      test_write_two_bytes();
      test_random_mix(200);
      test_back_to_back(80);
      test_random_mix(200);
      req_valid <= 1'b0;
      while (pending_packet_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ servo_instruction_packet_builder_core.f @@
+incdir+rtl
rtl/sipb_pkg.sv
rtl/sipb_front.sv
rtl/sipb_queue.sv
rtl/sipb_back.sv
rtl/servo_instruction_packet_builder_core.sv
rtl/sipb_checker.sv
tb/sv/servo_instruction_packet_builder_core_test.sv
